// File: hw/rtl/gmdfs_pkg.sv
// shared types and constants of the grid maze path finder
// no dependencies, compiled first
package gmdfs_pkg;

  localparam int COORD_W    = 6;
  localparam int DIR_W      = 3;
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_NUM    = 6;

  localparam int DEFAULT_MAX_ROWS = 32;
  localparam int DEFAULT_MAX_COLS = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL    = 3'd5;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET_VAL = 6'd1;

  // step direction codes
  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SOLVE = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PROBE,
    ST_TEST,
    ST_POP
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIR_W-1:0]   dir;
  } stack_entry_t;

endpackage

// File: hw/rtl/gmdfs_if.sv
// channel interfaces of the grid maze path finder: item input, result output, config write
// depends on gmdfs_pkg
interface gmdfs_item_if import gmdfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [COORD_W-1:0]    cell_row;
  logic [COORD_W-1:0]    cell_col;
  logic                  cell_value;
  logic [IDX_W-1:0]      entry_index;

  modport source (output valid, func, cell_row, cell_col, cell_value, entry_index,
                  input ready);
  modport sink   (input valid, func, cell_row, cell_col, cell_value, entry_index,
                  output ready);
endinterface

interface gmdfs_result_if import gmdfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  path_found;
  logic [LEN_W-1:0]      path_length;
  logic [COORD_W-1:0]    step_row;
  logic [COORD_W-1:0]    step_col;
  logic [DIR_W-1:0]      step_dir;
  logic                  entry_valid;

  modport source (output valid, path_found, path_length, step_row, step_col, step_dir,
                  entry_valid, input ready);
  modport sink   (input valid, path_found, path_length, step_row, step_col, step_dir,
                  entry_valid, output ready);
endinterface

interface gmdfs_cfg_if import gmdfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/grid_maze_dfs_path_finder.sv
// grid maze path finder: depth-first walk over a cell ram with a path stack ram
// load and unused func: result registered on acceptance; read: registered stack ram read first
// solve: in-grid probe: PROBE, TEST (cell ram read); off-grid side, goal: PROBE; pop: POP;
// one item at a time, the walk is bound by the single read port of the cell ram
// after reset a clearing pass writes 0 to all MAX_ROWS*MAX_COLS cells before items are taken
// depends on gmdfs_pkg, gmdfs_if, gmdfs_ram
module grid_maze_dfs_path_finder import gmdfs_pkg::*; #(
  parameter int MAX_ROWS = DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = DEFAULT_MAX_COLS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gmdfs_item_if.sink   item_i,
  gmdfs_result_if.source result_o,
  gmdfs_cfg_if.sink    cfg_i
);

  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int ENTRY_W = $bits(stack_entry_t);
  localparam int NB_W    = COORD_W + 1;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    cell_addr = ADDR_W'((int'(r) - 1) * MAX_COLS + (int'(c) - 1));
  endfunction

  function automatic logic in_storage(input logic [COORD_W-1:0] r,
                                      input logic [COORD_W-1:0] c);
    in_storage = (r != '0) && (int'(r) <= MAX_ROWS) && (c != '0) && (int'(c) <= MAX_COLS);
  endfunction

  // configuration
  logic [CFG_DATA_W-1:0] cfg_q [CFG_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_q[i] <= CFG_RESET_VAL;
      end
    end else if (cfg_i.valid && (int'(cfg_i.index) < CFG_NUM)) begin
      cfg_q[cfg_i.index] <= cfg_i.data;
    end
  end

  assign cfg_i.ready = 1'b1;

  logic [COORD_W-1:0] h_sat, w_sat;
  assign h_sat = (int'(cfg_q[REG_GRID_HEIGHT]) > MAX_ROWS) ? COORD_W'(MAX_ROWS)
                                                            : cfg_q[REG_GRID_HEIGHT];
  assign w_sat = (int'(cfg_q[REG_GRID_WIDTH]) > MAX_COLS) ? COORD_W'(MAX_COLS)
                                                           : cfg_q[REG_GRID_WIDTH];

  // state
  state_e             state_q, state_d;
  logic [COORD_W-1:0] r_q, r_d, c_q, c_d;
  logic [1:0]         k_q, k_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               solved_q, solved_d;
  logic [ADDR_W-1:0]  clr_q, clr_d;
  logic               hit_q, hit_d;

  // rams
  logic              maze_we, maze_re, maze_wdata, maze_rdata;
  logic [ADDR_W-1:0] maze_waddr, maze_raddr;
  logic              stk_we, stk_re;
  logic [ADDR_W-1:0] stk_waddr, stk_raddr;
  stack_entry_t      stk_wdata, stk_rdata;
  logic [ENTRY_W-1:0] stk_rdata_raw;

  gmdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_maze_ram (
    .clk_i   (clk_i),
    .we_i    (maze_we),
    .waddr_i (maze_waddr),
    .wdata_i (maze_wdata),
    .re_i    (maze_re),
    .raddr_i (maze_raddr),
    .rdata_o (maze_rdata)
  );

  gmdfs_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata_raw)
  );

  assign stk_rdata = stack_entry_t'(stk_rdata_raw);

  // neighbor of the walker in the direction under test
  logic [NB_W-1:0]    nr, nc;
  logic               nb_in_grid;
  logic [DIR_W-1:0]   dir_code;

  always_comb begin
    nr       = {1'b0, r_q};
    nc       = {1'b0, c_q};
    dir_code = DIR_NONE;
    case (k_q)
      2'd0: begin nc = nc + NB_W'(1); dir_code = DIR_RIGHT; end
      2'd1: begin nr = nr + NB_W'(1); dir_code = DIR_DOWN;  end
      2'd2: begin nc = nc - NB_W'(1); dir_code = DIR_LEFT;  end
      2'd3: begin nr = nr - NB_W'(1); dir_code = DIR_UP;    end
      default: ;
    endcase
    // off-by-one wraps land above any height, so the upper-bound compare catches them
    nb_in_grid = (nr != '0) && (nr <= {1'b0, h_sat}) && (nc != '0) && (nc <= {1'b0, w_sat});
  end

  logic at_goal, stack_room, out_load, out_valid_q, item_fire, backtrack;
  logic item_ready;
  assign at_goal    = (r_q == cfg_q[REG_GOAL_ROW]) && (c_q == cfg_q[REG_GOAL_COL]);
  assign stack_room = int'(count_q) < CELLS;
  assign item_fire  = item_i.valid && item_i.ready;

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    count_d    = count_q;
    solved_d   = solved_q;
    clr_d      = clr_q;
    hit_d      = hit_q;
    maze_we    = 1'b0;
    maze_waddr = '0;
    maze_wdata = 1'b0;
    maze_re    = 1'b0;
    maze_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = '0;
    out_load   = 1'b0;
    backtrack  = 1'b0;
    item_ready = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        maze_we    = 1'b1;
        maze_waddr = clr_q;
        clr_d      = clr_q + ADDR_W'(1);
        if (int'(clr_q) == CELLS - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = !out_valid_q || result_o.ready;
        if (item_fire) begin
          case (func_e'(item_i.func))
            FUNC_LOAD: begin
              maze_we    = in_storage(item_i.cell_row, item_i.cell_col);
              maze_waddr = cell_addr(item_i.cell_row, item_i.cell_col);
              maze_wdata = item_i.cell_value;
              out_load   = 1'b1;
            end
            FUNC_SOLVE: begin
              r_d        = cfg_q[REG_START_ROW];
              c_d        = cfg_q[REG_START_COL];
              k_d        = '0;
              count_d    = '0;
              maze_we    = in_storage(cfg_q[REG_START_ROW], cfg_q[REG_START_COL]);
              maze_waddr = cell_addr(cfg_q[REG_START_ROW], cfg_q[REG_START_COL]);
              maze_wdata = 1'b1;
              state_d    = ST_PROBE;
            end
            FUNC_READ: begin
              hit_d     = int'(item_i.entry_index) < int'(count_q);
              stk_re    = 1'b1;
              stk_raddr = ADDR_W'(item_i.entry_index);
              state_d   = ST_READ;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_PROBE: begin
        if (at_goal) begin
          if (stack_room) begin
            stk_we    = 1'b1;
            stk_waddr = ADDR_W'(count_q);
            stk_wdata = '{row: r_q, col: c_q, dir: DIR_RIGHT};
            count_d   = count_q + CNT_W'(1);
          end
          solved_d = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else if (nb_in_grid) begin
          maze_re    = 1'b1;
          maze_raddr = cell_addr(nr[COORD_W-1:0], nc[COORD_W-1:0]);
          state_d    = ST_TEST;
        end else if (k_q == 2'd3) begin
          backtrack = 1'b1;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      ST_TEST: begin
        if (!maze_rdata) begin
          // open neighbor: push the walker, step, mark the new cell visited
          if (stack_room) begin
            stk_we    = 1'b1;
            stk_waddr = ADDR_W'(count_q);
            stk_wdata = '{row: r_q, col: c_q, dir: dir_code};
            count_d   = count_q + CNT_W'(1);
          end
          r_d        = nr[COORD_W-1:0];
          c_d        = nc[COORD_W-1:0];
          k_d        = '0;
          maze_we    = 1'b1;
          maze_waddr = cell_addr(nr[COORD_W-1:0], nc[COORD_W-1:0]);
          maze_wdata = 1'b1;
          state_d    = ST_PROBE;
        end else if (k_q == 2'd3) begin
          backtrack = 1'b1;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_PROBE;
        end
      end
      ST_POP: begin
        r_d     = stk_rdata.row;
        c_d     = stk_rdata.col;
        k_d     = '0;
        state_d = ST_PROBE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (backtrack) begin
      if (count_q == '0) begin
        solved_d = 1'b0;
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end else begin
        count_d   = count_q - CNT_W'(1);
        stk_re    = 1'b1;
        stk_raddr = ADDR_W'(count_q - CNT_W'(1));
        state_d   = ST_POP;
      end
    end
  end

  assign item_i.ready = item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      count_q  <= '0;
      solved_q <= 1'b0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      solved_q <= solved_d;
      clr_q    <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    c_q   <= c_d;
    k_q   <= k_d;
    hit_q <= hit_d;
  end

  // result register
  logic               res_found_q, res_valid_entry_q;
  logic [LEN_W-1:0]   res_len_q;
  logic [COORD_W-1:0] res_row_q, res_col_q;
  logic [DIR_W-1:0]   res_dir_q;
  logic               read_hit;

  assign read_hit = (state_q == ST_READ) && hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_found_q       <= solved_d;
      res_len_q         <= LEN_W'(count_d);
      res_row_q         <= read_hit ? stk_rdata.row : '0;
      res_col_q         <= read_hit ? stk_rdata.col : '0;
      res_dir_q         <= read_hit ? stk_rdata.dir : DIR_NONE;
      res_valid_entry_q <= read_hit;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.path_found  = res_found_q;
  assign result_o.path_length = res_len_q;
  assign result_o.step_row    = res_row_q;
  assign result_o.step_col    = res_col_q;
  assign result_o.step_dir    = res_dir_q;
  assign result_o.entry_valid = res_valid_entry_q;

endmodule

// File: hw/rtl/gmdfs_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module gmdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
